/* design/snmpgr_pkg.sv */
// Shared types and constants for the SNMPv1 GET request checker.
// Holds parse phases, result kinds, status codes, register indexes and the
// structs passed between the configuration, parser and output queue modules.
`timescale 1ns / 1ps
`default_nettype none

package snmpgr_pkg;

    typedef enum logic [4:0] {
        PH_SEQ_TAG, PH_SEQ_LEN, PH_VER_TAG, PH_VER_LEN, PH_VER_VAL,
        PH_COM_TAG, PH_COM_LEN, PH_COM_BYTES, PH_PDU_TAG, PH_PDU_LEN,
        PH_ID_TAG, PH_ID_LEN, PH_ID_BYTES, PH_ERR_TAG, PH_ERR_LEN, PH_ERR_VAL,
        PH_EIX_TAG, PH_EIX_LEN, PH_EIX_VAL, PH_LIST_TAG, PH_LIST_LEN,
        PH_VB_TAG, PH_VB_LEN, PH_OID_TAG, PH_OID_LEN, PH_OID_BYTES,
        PH_NULL_TAG, PH_NULL_LEN, PH_DONE, PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        KIND_OID_BYTE = 2'd0,
        KIND_VB_DONE  = 2'd1,
        KIND_ACCEPT   = 2'd2,
        KIND_REJECT   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_HEADER    = 4'd1,
        ST_VERSION   = 4'd2,
        ST_COMMUNITY = 4'd3,
        ST_PDU_TYPE  = 4'd4,
        ST_ID_FIELDS = 4'd5,
        ST_VB_LIST   = 4'd6,
        ST_TOO_MANY  = 4'd7,
        ST_TRUNCATED = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        CFG_COMMUNITY_BYTES  = 2'd0,
        CFG_COMMUNITY_LENGTH = 2'd1,
        CFG_MAX_BINDINGS     = 2'd2,
        CFG_MAX_LIST_LENGTH  = 2'd3
    } t_cfg_index;

    // BER tags
    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;
    localparam logic [7:0] TAG_OID      = 8'h06;
    localparam logic [7:0] TAG_NULL     = 8'h05;
    localparam logic [7:0] TAG_GET      = 8'hA0;
    localparam logic [7:0] TAG_GETNEXT  = 8'hA1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [63:0] community_bytes;
        logic [3:0]  community_length;
        logic [7:0]  max_bindings;
        logic [7:0]  max_list_length;
    } t_cfg;

    typedef struct packed {
        t_kind       item_kind;
        logic [7:0]  binding_index;
        logic [7:0]  oid_value;
        logic [7:0]  oid_length;
        logic        is_get_next;
        t_status     status;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic    push0;
        logic    push1;
        t_result res0;
        t_result res1;
    } t_push;

endpackage

`default_nettype wire

/* design/snmpgr_cfg_regs.sv */
// Configuration register file for the SNMPv1 GET request checker.
// Decodes the write channel into the four control registers; uses snmpgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snmpgr_cfg_regs (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire  [1:0]              i_cfg_index,
    input  wire  [63:0]             i_cfg_data,
    output snmpgr_pkg::t_cfg        o_cfg
);
    import snmpgr_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_COMMUNITY_BYTES:  n_cfg.community_bytes  = i_cfg_data;
                CFG_COMMUNITY_LENGTH: n_cfg.community_length = i_cfg_data[3:0];
                CFG_MAX_BINDINGS:     n_cfg.max_bindings     = i_cfg_data[7:0];
                CFG_MAX_LIST_LENGTH:  n_cfg.max_list_length  = i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.community_bytes  <= 64'd0;
            r_cfg.community_length <= 4'd0;
            r_cfg.max_bindings     <= 8'd8;
            r_cfg.max_list_length  <= 8'd255;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

/* design/snmpgr_parser.sv */
// Byte-wise BER parser: one phase step per accepted payload byte.
// Produces up to two results per byte (OID byte or varbind done, then verdict).
// Depends on snmpgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snmpgr_parser #(
    parameter int COMMUNITY_MAX_BYTES = 8
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire  [7:0]              i_data_byte,
    input  wire                     i_last_byte,
    input  snmpgr_pkg::t_cfg        i_cfg,
    output snmpgr_pkg::t_push       o_push
);
    import snmpgr_pkg::*;

    t_phase      r_phase, n_phase, ph;
    logic [7:0]  r_pkt_rem, n_pkt_rem;
    logic [7:0]  r_vb_rem, n_vb_rem;
    logic [7:0]  r_field, n_field;
    logic [7:0]  r_bind, n_bind;
    t_status     r_fault, n_fault;
    logic        r_pdu_next, n_pdu_next;
    logic [7:0]  r_oid_left, n_oid_left;

    logic        emit;
    t_result     item;
    t_result     verdict;
    logic [7:0]  b;
    logic [7:0]  com_byte;
    logic [7:0]  oid_left_dec;
    logic [7:0]  id_left_dec;

    assign b        = i_data_byte;
    assign com_byte = i_cfg.community_bytes[{r_field[2:0], 3'b000} +: 8];

    always_comb begin
        n_phase    = r_phase;
        n_pkt_rem  = r_pkt_rem;
        n_vb_rem   = r_vb_rem;
        n_field    = r_field;
        n_bind     = r_bind;
        n_fault    = r_fault;
        n_pdu_next = r_pdu_next;
        n_oid_left = r_oid_left;
        ph         = r_phase;
        emit       = 1'b0;
        item       = '0;
        verdict    = '0;
        oid_left_dec = (r_oid_left != 8'd0) ? r_oid_left - 8'd1 : 8'd0;
        id_left_dec  = (r_field != 8'd0) ? r_field - 8'd1 : 8'd0;

        // length accounting runs ahead of the phase decode
        if (ph != PH_SEQ_TAG && ph != PH_SEQ_LEN && ph != PH_DRAIN) begin
            if (r_pkt_rem == 8'd0) begin
                n_fault = ST_HEADER;
                ph      = PH_DRAIN;
            end else begin
                n_pkt_rem = r_pkt_rem - 8'd1;
            end
        end
        if (ph >= PH_VB_TAG && ph <= PH_NULL_LEN) begin
            if (r_vb_rem == 8'd0) begin
                n_fault = ST_VB_LIST;
                ph      = PH_DRAIN;
            end else begin
                n_vb_rem = r_vb_rem - 8'd1;
            end
        end

        unique case (ph)
            PH_SEQ_TAG: begin
                if (b != TAG_SEQUENCE) begin n_fault = ST_HEADER; ph = PH_DRAIN; end
                else ph = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
                n_pkt_rem = b;
                ph        = PH_VER_TAG;
            end
            PH_VER_TAG: begin
                if (b != TAG_INTEGER) begin n_fault = ST_VERSION; ph = PH_DRAIN; end
                else ph = PH_VER_LEN;
            end
            PH_VER_LEN: begin
                if (b != 8'h01) begin n_fault = ST_VERSION; ph = PH_DRAIN; end
                else ph = PH_VER_VAL;
            end
            PH_VER_VAL: begin
                if (b != 8'h00) begin n_fault = ST_VERSION; ph = PH_DRAIN; end
                else ph = PH_COM_TAG;
            end
            PH_COM_TAG: begin
                if (b != TAG_OCTETS) begin n_fault = ST_COMMUNITY; ph = PH_DRAIN; end
                else ph = PH_COM_LEN;
            end
            PH_COM_LEN: begin
                if (b > n_pkt_rem || b != {4'd0, i_cfg.community_length} ||
                    b > 8'(COMMUNITY_MAX_BYTES)) begin
                    n_fault = ST_COMMUNITY;
                    ph      = PH_DRAIN;
                end else begin
                    n_field = 8'd0;
                    ph      = (b == 8'd0) ? PH_PDU_TAG : PH_COM_BYTES;
                end
            end
            PH_COM_BYTES: begin
                if (b != com_byte) begin
                    n_fault = ST_COMMUNITY;
                    ph      = PH_DRAIN;
                end else begin
                    n_field = r_field + 8'd1;
                    if (n_field >= {4'd0, i_cfg.community_length}) ph = PH_PDU_TAG;
                end
            end
            PH_PDU_TAG: begin
                if (b == TAG_GET) begin
                    n_pdu_next = 1'b0;
                    ph         = PH_PDU_LEN;
                end else if (b == TAG_GETNEXT) begin
                    n_pdu_next = 1'b1;
                    ph         = PH_PDU_LEN;
                end else begin
                    n_fault = ST_PDU_TYPE;
                    ph      = PH_DRAIN;
                end
            end
            PH_PDU_LEN: begin
                if (b != n_pkt_rem) begin n_fault = ST_HEADER; ph = PH_DRAIN; end
                else ph = PH_ID_TAG;
            end
            PH_ID_TAG: begin
                if (b != TAG_INTEGER) begin n_fault = ST_ID_FIELDS; ph = PH_DRAIN; end
                else ph = PH_ID_LEN;
            end
            PH_ID_LEN: begin
                if (b > n_pkt_rem) begin
                    n_fault = ST_ID_FIELDS;
                    ph      = PH_DRAIN;
                end else begin
                    n_field = b;
                    ph      = (b == 8'd0) ? PH_ERR_TAG : PH_ID_BYTES;
                end
            end
            PH_ID_BYTES: begin
                n_field = id_left_dec;
                if (id_left_dec == 8'd0) ph = PH_ERR_TAG;
            end
            PH_ERR_TAG: begin
                if (b != TAG_INTEGER) begin n_fault = ST_ID_FIELDS; ph = PH_DRAIN; end
                else ph = PH_ERR_LEN;
            end
            PH_ERR_LEN: begin
                if (b != 8'h01) begin n_fault = ST_ID_FIELDS; ph = PH_DRAIN; end
                else ph = PH_ERR_VAL;
            end
            PH_ERR_VAL: ph = PH_EIX_TAG;
            PH_EIX_TAG: begin
                if (b != TAG_INTEGER) begin n_fault = ST_ID_FIELDS; ph = PH_DRAIN; end
                else ph = PH_EIX_LEN;
            end
            PH_EIX_LEN: begin
                if (b != 8'h01) begin n_fault = ST_ID_FIELDS; ph = PH_DRAIN; end
                else ph = PH_EIX_VAL;
            end
            PH_EIX_VAL: ph = PH_LIST_TAG;
            PH_LIST_TAG: begin
                if (b != TAG_SEQUENCE) begin n_fault = ST_VB_LIST; ph = PH_DRAIN; end
                else ph = PH_LIST_LEN;
            end
            PH_LIST_LEN: begin
                if (b != n_pkt_rem || b > i_cfg.max_list_length) begin
                    n_fault = ST_VB_LIST;
                    ph      = PH_DRAIN;
                end else begin
                    n_vb_rem = b;
                    n_bind   = 8'd0;
                    ph       = (b == 8'd0) ? PH_DONE : PH_VB_TAG;
                end
            end
            PH_VB_TAG: begin
                if (r_bind >= i_cfg.max_bindings) begin
                    n_fault = ST_TOO_MANY;
                    ph      = PH_DRAIN;
                end else if (b != TAG_SEQUENCE) begin
                    n_fault = ST_VB_LIST;
                    ph      = PH_DRAIN;
                end else begin
                    ph = PH_VB_LEN;
                end
            end
            PH_VB_LEN: begin
                if (b > n_vb_rem || b < 8'd4) begin
                    n_fault = ST_VB_LIST;
                    ph      = PH_DRAIN;
                end else begin
                    n_field = b;
                    ph      = PH_OID_TAG;
                end
            end
            PH_OID_TAG: begin
                if (b != TAG_OID) begin n_fault = ST_VB_LIST; ph = PH_DRAIN; end
                else ph = PH_OID_LEN;
            end
            PH_OID_LEN: begin
                if (r_field < 8'd4 || b != r_field - 8'd4) begin
                    n_fault = ST_VB_LIST;
                    ph      = PH_DRAIN;
                end else begin
                    n_oid_left = b;
                    ph         = (b == 8'd0) ? PH_NULL_TAG : PH_OID_BYTES;
                end
            end
            PH_OID_BYTES: begin
                emit               = 1'b1;
                item.item_kind     = KIND_OID_BYTE;
                item.binding_index = r_bind;
                item.oid_value     = b;
                n_oid_left         = oid_left_dec;
                if (oid_left_dec == 8'd0) ph = PH_NULL_TAG;
            end
            PH_NULL_TAG: begin
                if (b != TAG_NULL) begin n_fault = ST_VB_LIST; ph = PH_DRAIN; end
                else ph = PH_NULL_LEN;
            end
            PH_NULL_LEN: begin
                if (b != 8'h00) begin
                    n_fault = ST_VB_LIST;
                    ph      = PH_DRAIN;
                end else begin
                    emit               = 1'b1;
                    item.item_kind     = KIND_VB_DONE;
                    item.binding_index = r_bind;
                    item.oid_length    = r_field - 8'd4;
                    n_bind             = r_bind + 8'd1;
                    ph                 = (n_vb_rem == 8'd0) ? PH_DONE : PH_VB_TAG;
                end
            end
            default: ;
        endcase

        item.is_get_next   = n_pdu_next;
        item.last_of_run   = !i_last_byte;

        verdict.binding_index = n_bind;
        verdict.is_get_next   = n_pdu_next;
        verdict.last_of_run   = 1'b1;
        if (ph == PH_DRAIN) begin
            verdict.item_kind = KIND_REJECT;
            verdict.status    = n_fault;
        end else if (ph == PH_DONE) begin
            verdict.item_kind = KIND_ACCEPT;
            verdict.status    = ST_OK;
        end else begin
            verdict.item_kind = KIND_REJECT;
            verdict.status    = ST_TRUNCATED;
        end

        n_phase = ph;
        // end of packet: drop all packet state
        if (i_last_byte) begin
            n_phase    = PH_SEQ_TAG;
            n_pkt_rem  = 8'd0;
            n_vb_rem   = 8'd0;
            n_field    = 8'd0;
            n_bind     = 8'd0;
            n_fault    = ST_OK;
            n_pdu_next = 1'b0;
            n_oid_left = 8'd0;
        end

        o_push.push0 = i_accept && (emit || i_last_byte);
        o_push.push1 = i_accept && emit && i_last_byte;
        o_push.res0  = emit ? item : verdict;
        o_push.res1  = verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEQ_TAG;
            r_pkt_rem  <= 8'd0;
            r_vb_rem   <= 8'd0;
            r_field    <= 8'd0;
            r_bind     <= 8'd0;
            r_fault    <= ST_OK;
            r_pdu_next <= 1'b0;
            r_oid_left <= 8'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_pkt_rem  <= n_pkt_rem;
            r_vb_rem   <= n_vb_rem;
            r_field    <= n_field;
            r_bind     <= n_bind;
            r_fault    <= n_fault;
            r_pdu_next <= n_pdu_next;
            r_oid_left <= n_oid_left;
        end
    end

    a_second_is_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.push1 |-> (o_push.res1.item_kind == KIND_ACCEPT ||
                          o_push.res1.item_kind == KIND_REJECT) &&
                         (o_push.res0.item_kind == KIND_OID_BYTE ||
                          o_push.res0.item_kind == KIND_VB_DONE))
        else $error("second result of a byte is not a verdict");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last_byte) |=> (r_phase == PH_SEQ_TAG && r_fault == ST_OK &&
                                       r_bind == 8'd0))
        else $error("packet state not cleared after last byte");

    a_drain_has_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DRAIN) |-> (r_fault != ST_OK))
        else $error("drain phase without a fault code");

endmodule

`default_nettype wire

/* design/snmpgr_out_queue.sv */
// Small result queue between the parser and the output stream.
// Takes up to two results per cycle and delivers one; depends on snmpgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module snmpgr_out_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  snmpgr_pkg::t_push       i_push,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire                     i_ready,
    output snmpgr_pkg::t_result     o_result
);
    import snmpgr_pkg::*;

    t_result                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]  r_rd, n_rd;
    logic [QUEUE_PTR_W-1:0]  r_wr, n_wr;
    logic [QUEUE_CNT_W-1:0]  r_cnt, n_cnt;
    logic                    pop;
    logic [QUEUE_PTR_W-1:0]  wr_next;

    // room for the worst case of two results from one byte
    assign o_space  = (r_cnt <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));
    assign o_valid  = (r_cnt != '0);
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;
    assign wr_next  = r_wr + QUEUE_PTR_W'(1);

    always_comb begin
        n_rd  = pop ? r_rd + QUEUE_PTR_W'(1) : r_rd;
        n_wr  = r_wr + QUEUE_PTR_W'(i_push.push0) + QUEUE_PTR_W'(i_push.push1);
        n_cnt = r_cnt + QUEUE_CNT_W'(i_push.push0) + QUEUE_CNT_W'(i_push.push1)
              - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push0) r_mem[r_wr] <= i_push.res0;
        if (i_push.push1) r_mem[wr_next] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_needs_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push1 |-> (i_push.push0 && o_space))
        else $error("double push without room");

endmodule

`default_nettype wire

/* design/snmp_v1_get_request_checker.sv */
// Top level of the SNMPv1 GET/GETNEXT request checker.
// Instantiates snmpgr_cfg_regs, snmpgr_parser and snmpgr_out_queue; uses snmpgr_pkg.
//
//  Channel   Dir  Handshake                  Payload
//  s_axis    in   i_s_axis_tvalid/o_..tready  tdata data_byte, tlast last_byte
//  m_axis    out  o_m_axis_tvalid/i_..tready  tdata result fields, tuser kind, tlast
//  cfg       in   i_cfg_valid/o_cfg_ready     i_cfg_index, i_cfg_data
//
//  One payload byte per cycle while input ready is high; each byte is parsed in the cycle
//  it is accepted and its results are registered into the output queue.
//  At most two results per byte (the second only on the last byte of a packet).
//  The four-entry output queue sets the stall: input ready drops while fewer than
//  two entries are free. Configuration writes are always ready.
//  Synchronous active-low reset clears parse state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module snmp_v1_get_request_checker #(
    parameter int COMMUNITY_MAX_BYTES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] binding_index, [15:8] oid_value, [23:16] oid_length,
    // [24] is_get_next, [28:25] status, [31:29] zero
    output logic [31:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] item_kind
    output logic        o_m_axis_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);
    import snmpgr_pkg::*;

    t_cfg    cfg;
    t_push   push;
    t_result res;
    logic    space;
    logic    accept;

    assign o_s_axis_tready = space;
    assign accept          = i_s_axis_tvalid && space;

    snmpgr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    snmpgr_parser #(
        .COMMUNITY_MAX_BYTES (COMMUNITY_MAX_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_axis_tdata),
        .i_last_byte (i_s_axis_tlast),
        .i_cfg       (cfg),
        .o_push      (push)
    );

    snmpgr_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space  (space),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (res)
    );

    assign o_m_axis_tdata = {3'b000, res.status, res.is_get_next, res.oid_length,
                             res.oid_value, res.binding_index};
    assign o_m_axis_tuser = res.item_kind;
    assign o_m_axis_tlast = res.last_of_run;

endmodule

`default_nettype wire

/* sim/snmpgr_stream_checker.sv */
`timescale 1ns / 1ps
// Stream checker for snmp_v1_get_request_checker: tracks register writes, parses every
// accepted payload byte on its own and compares each emitted result in order.
// Depends on snmpgr_pkg for parse phases, result kinds, status codes, register indexes, tags.
module snmpgr_stream_checker #(
    parameter int COMMUNITY_MAX_BYTES = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    input  wire         o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,
    input  wire         i_s_axis_tlast,
    input  wire         o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    input  wire  [31:0] o_m_axis_tdata,
    input  wire  [1:0]  o_m_axis_tuser,
    input  wire         o_m_axis_tlast,
    input  wire         i_cfg_valid,
    input  wire         o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_results,
    output int          o_accepts,
    output int          o_rejects
);
    import snmpgr_pkg::*;

    // register copies
    logic [63:0] comm_bytes;
    logic [3:0]  comm_len;
    logic [7:0]  bind_limit;
    logic [7:0]  list_limit;

    // per-packet parse state
    t_phase      phase;
    logic [8:0]  pkt_left;
    logic [8:0]  list_left;
    logic [7:0]  fld_cnt;
    logic [7:0]  vb_count;
    logic [7:0]  oid_left;
    t_status     fault;
    logic        next_pdu;

    t_result     due_results[$];
    int          mismatches = 0;
    int          results = 0;
    int          accepts = 0;
    int          rejects = 0;

    assign o_mismatches = mismatches;
    assign o_results    = results;
    assign o_accepts    = accepts;
    assign o_rejects    = rejects;

    task automatic clear_packet();
        phase     = PH_SEQ_TAG;
        pkt_left  = '0;
        list_left = '0;
        fld_cnt   = '0;
        vb_count  = '0;
        oid_left  = '0;
        fault     = ST_OK;
        next_pdu  = 1'b0;
    endtask

    task automatic abort_packet(input t_status code);
        fault = code;
        phase = PH_DRAIN;
    endtask

    task automatic note_result(input t_kind kind, input logic [7:0] idx,
                               input logic [7:0] val, input logic [7:0] len,
                               input t_status st);
        t_result r;
        r.item_kind     = kind;
        r.binding_index = idx;
        r.oid_value     = val;
        r.oid_length    = len;
        r.is_get_next   = next_pdu;
        r.status        = st;
        r.last_of_run   = 1'b0;
        due_results.push_back(r);
    endtask

    task automatic parse_payload_byte(input logic [7:0] b, input logic last);
        int      n_before;
        t_result r;
        n_before = due_results.size();

        // outer sequence byte budget, then the varbind list budget
        if (phase != PH_SEQ_TAG && phase != PH_SEQ_LEN && phase != PH_DRAIN) begin
            if (pkt_left == 0) abort_packet(ST_HEADER);
            else pkt_left = pkt_left - 1'b1;
        end
        if (phase >= PH_VB_TAG && phase <= PH_NULL_LEN) begin
            if (list_left == 0) abort_packet(ST_VB_LIST);
            else list_left = list_left - 1'b1;
        end

        case (phase)
            PH_SEQ_TAG: if (b != TAG_SEQUENCE) abort_packet(ST_HEADER); else phase = PH_SEQ_LEN;
            PH_SEQ_LEN: begin
                pkt_left = {1'b0, b};
                phase    = PH_VER_TAG;
            end
            PH_VER_TAG: if (b != TAG_INTEGER) abort_packet(ST_VERSION); else phase = PH_VER_LEN;
            PH_VER_LEN: if (b != 8'd1) abort_packet(ST_VERSION); else phase = PH_VER_VAL;
            PH_VER_VAL: if (b != 8'd0) abort_packet(ST_VERSION); else phase = PH_COM_TAG;
            PH_COM_TAG: if (b != TAG_OCTETS) abort_packet(ST_COMMUNITY); else phase = PH_COM_LEN;
            PH_COM_LEN: begin
                if (b > pkt_left || b != comm_len || b > COMMUNITY_MAX_BYTES) begin
                    abort_packet(ST_COMMUNITY);
                end else begin
                    fld_cnt = '0;
                    phase   = (b == 0) ? PH_PDU_TAG : PH_COM_BYTES;
                end
            end
            PH_COM_BYTES: begin
                if (b != comm_bytes[fld_cnt[2:0]*8 +: 8]) begin
                    abort_packet(ST_COMMUNITY);
                end else begin
                    fld_cnt = fld_cnt + 1'b1;
                    if (fld_cnt >= comm_len) phase = PH_PDU_TAG;
                end
            end
            PH_PDU_TAG: begin
                if (b == TAG_GET) begin
                    next_pdu = 1'b0;
                    phase    = PH_PDU_LEN;
                end else if (b == TAG_GETNEXT) begin
                    next_pdu = 1'b1;
                    phase    = PH_PDU_LEN;
                end else begin
                    abort_packet(ST_PDU_TYPE);
                end
            end
            PH_PDU_LEN: if (b != pkt_left) abort_packet(ST_HEADER); else phase = PH_ID_TAG;
            PH_ID_TAG:  if (b != TAG_INTEGER) abort_packet(ST_ID_FIELDS); else phase = PH_ID_LEN;
            PH_ID_LEN: begin
                if (b > pkt_left) begin
                    abort_packet(ST_ID_FIELDS);
                end else begin
                    fld_cnt = b;
                    phase   = (b == 0) ? PH_ERR_TAG : PH_ID_BYTES;
                end
            end
            PH_ID_BYTES: begin
                if (fld_cnt > 0) fld_cnt = fld_cnt - 1'b1;
                if (fld_cnt == 0) phase = PH_ERR_TAG;
            end
            PH_ERR_TAG: if (b != TAG_INTEGER) abort_packet(ST_ID_FIELDS); else phase = PH_ERR_LEN;
            PH_ERR_LEN: if (b != 8'd1) abort_packet(ST_ID_FIELDS); else phase = PH_ERR_VAL;
            PH_ERR_VAL: phase = PH_EIX_TAG;
            PH_EIX_TAG: if (b != TAG_INTEGER) abort_packet(ST_ID_FIELDS); else phase = PH_EIX_LEN;
            PH_EIX_LEN: if (b != 8'd1) abort_packet(ST_ID_FIELDS); else phase = PH_EIX_VAL;
            PH_EIX_VAL: phase = PH_LIST_TAG;
            PH_LIST_TAG: if (b != TAG_SEQUENCE) abort_packet(ST_VB_LIST); else phase = PH_LIST_LEN;
            PH_LIST_LEN: begin
                if (b != pkt_left || b > list_limit) begin
                    abort_packet(ST_VB_LIST);
                end else begin
                    list_left = {1'b0, b};
                    vb_count  = '0;
                    phase     = (b == 0) ? PH_DONE : PH_VB_TAG;
                end
            end
            PH_VB_TAG: begin
                if (vb_count >= bind_limit) abort_packet(ST_TOO_MANY);
                else if (b != TAG_SEQUENCE) abort_packet(ST_VB_LIST);
                else phase = PH_VB_LEN;
            end
            PH_VB_LEN: begin
                if (b > list_left || b < 8'd4) begin
                    abort_packet(ST_VB_LIST);
                end else begin
                    fld_cnt = b;
                    phase   = PH_OID_TAG;
                end
            end
            PH_OID_TAG: if (b != TAG_OID) abort_packet(ST_VB_LIST); else phase = PH_OID_LEN;
            PH_OID_LEN: begin
                if (fld_cnt < 8'd4 || b != fld_cnt - 8'd4) begin
                    abort_packet(ST_VB_LIST);
                end else begin
                    oid_left = b;
                    phase    = (b == 0) ? PH_NULL_TAG : PH_OID_BYTES;
                end
            end
            PH_OID_BYTES: begin
                note_result(KIND_OID_BYTE, vb_count, b, 8'd0, ST_OK);
                if (oid_left > 0) oid_left = oid_left - 1'b1;
                if (oid_left == 0) phase = PH_NULL_TAG;
            end
            PH_NULL_TAG: if (b != TAG_NULL) abort_packet(ST_VB_LIST); else phase = PH_NULL_LEN;
            PH_NULL_LEN: begin
                if (b != 8'd0) begin
                    abort_packet(ST_VB_LIST);
                end else begin
                    note_result(KIND_VB_DONE, vb_count, 8'd0, fld_cnt - 8'd4, ST_OK);
                    vb_count = vb_count + 1'b1;
                    phase    = (list_left == 0) ? PH_DONE : PH_VB_TAG;
                end
            end
            default: ;
        endcase

        if (last) begin
            if (phase == PH_DRAIN) begin
                note_result(KIND_REJECT, vb_count, 8'd0, 8'd0, fault);
                rejects++;
            end else if (phase == PH_DONE) begin
                note_result(KIND_ACCEPT, vb_count, 8'd0, 8'd0, ST_OK);
                accepts++;
            end else begin
                note_result(KIND_REJECT, vb_count, 8'd0, 8'd0, ST_TRUNCATED);
                rejects++;
            end
            clear_packet();
        end

        // flag the final result caused by this byte
        if (due_results.size() > n_before) begin
            r = due_results.pop_back();
            r.last_of_run = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_result();
        t_result want;
        if (due_results.size() == 0) begin
            $error("result with nothing due: kind %0d tdata 0x%08h", o_m_axis_tuser,
                   o_m_axis_tdata);
            mismatches++;
        end else begin
            want = due_results.pop_front();
            results++;
            check_field("item_kind", want.item_kind, o_m_axis_tuser);
            check_field("binding_index", want.binding_index, o_m_axis_tdata[7:0]);
            check_field("oid_value", want.oid_value, o_m_axis_tdata[15:8]);
            check_field("oid_length", want.oid_length, o_m_axis_tdata[23:16]);
            check_field("is_get_next", want.is_get_next, o_m_axis_tdata[24]);
            check_field("status", want.status, o_m_axis_tdata[28:25]);
            check_field("last_of_run", want.last_of_run, o_m_axis_tlast);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            comm_bytes = '0;
            comm_len   = '0;
            bind_limit = 8'd8;
            list_limit = 8'd255;
            clear_packet();
            due_results.delete();
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) compare_result();
            if (i_s_axis_tvalid && o_s_axis_tready) parse_payload_byte(i_s_axis_tdata, i_s_axis_tlast);
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_COMMUNITY_BYTES:  comm_bytes = i_cfg_data;
                    CFG_COMMUNITY_LENGTH: comm_len   = i_cfg_data[3:0];
                    CFG_MAX_BINDINGS:     bind_limit = i_cfg_data[7:0];
                    CFG_MAX_LIST_LENGTH:  list_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
        o_pending <= due_results.size();
    end

endmodule

/* sim/snmp_v1_get_request_checker_tb.sv */
`timescale 1ns / 1ps
// Testbench top for snmp_v1_get_request_checker: builds SNMPv1 request payloads, sweeps
// the registers and the handshake pressure, and reports the verdict.
// Depends on snmpgr_pkg and snmpgr_stream_checker, which predicts and compares results.
module snmp_v1_get_request_checker_tb;
    import snmpgr_pkg::*;

    localparam int COMMUNITY_MAX_BYTES = 8;
    localparam int WATCHDOG_LIMIT      = 2000;
    localparam int HOLD_CYCLES         = 300;
    localparam int RANDOM_BYTES        = 1600;
    localparam int SETTING_COUNT       = 7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [7:0]  i_s_axis_tdata = 8'd0;
    logic        i_s_axis_tlast = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [63:0] i_cfg_data = 64'd0;
    wire         o_s_axis_tready;
    wire         o_m_axis_tvalid;
    wire  [31:0] o_m_axis_tdata;
    wire  [1:0]  o_m_axis_tuser;
    wire         o_m_axis_tlast;
    wire         o_cfg_ready;

    int mismatches;
    int pending;
    int results_checked;
    int accepts;
    int rejects;

    // stimulus bookkeeping
    logic [7:0]  payload[$];
    logic [63:0] gen_comm_bytes = 64'd0;
    logic [3:0]  gen_comm_len = 4'd0;
    logic [7:0]  gen_bind_limit = 8'd8;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          holds_asked = 0;
    int          holds_granted = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          bytes_sent = 0;
    int          requests_sent = 0;
    int          settings_used = 0;

    always #6 i_clk = ~i_clk;

    snmp_v1_get_request_checker #(
        .COMMUNITY_MAX_BYTES(COMMUNITY_MAX_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    snmpgr_stream_checker #(
        .COMMUNITY_MAX_BYTES(COMMUNITY_MAX_BYTES)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results_checked),
        .o_accepts      (accepts),
        .o_rejects      (rejects)
    );

    // receiver: random backpressure, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (holds_granted != holds_asked) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // end the run if no transaction moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("snmp_v1_get_request_checker regression: fail");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_payload();
        for (int i = 0; i < payload.size(); i++)
            push_byte(payload[i], i == payload.size() - 1);
        requests_sent++;
    endtask

    // wait until every result has drained and the parser has settled
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_settings(input logic [63:0] cb, input logic [3:0] cl,
                                 input logic [7:0] mb, input logic [7:0] ml);
        write_register(CFG_COMMUNITY_BYTES, cb);
        write_register(CFG_COMMUNITY_LENGTH, {60'd0, cl});
        write_register(CFG_MAX_BINDINGS, {56'd0, mb});
        write_register(CFG_MAX_LIST_LENGTH, {56'd0, ml});
        i_cfg_valid    <= 1'b0;
        gen_comm_bytes = cb;
        gen_comm_len   = cl;
        gen_bind_limit = mb;
        settings_used++;
    endtask

    // GET/GETNEXT request with random content, well-formed unless community_ok is clear
    task automatic compose_request(input int n_binds, input int oid_cap, input bit getnext,
                                   input bit community_ok);
        logic [7:0] binds[$];
        logic [7:0] pdu[$];
        logic [7:0] community[$];
        int         oid_n;
        int         id_n;
        int         k;
        for (int i = 0; i < n_binds; i++) begin
            oid_n = $urandom_range(0, oid_cap);
            binds.push_back(TAG_SEQUENCE);
            binds.push_back(8'(oid_n + 4));
            binds.push_back(TAG_OID);
            binds.push_back(8'(oid_n));
            repeat (oid_n) binds.push_back(8'($urandom));
            binds.push_back(TAG_NULL);
            binds.push_back(8'h00);
        end
        id_n = $urandom_range(0, 4);
        pdu.push_back(TAG_INTEGER);
        pdu.push_back(8'(id_n));
        repeat (id_n) pdu.push_back(8'($urandom));
        repeat (2) begin
            pdu.push_back(TAG_INTEGER);
            pdu.push_back(8'd1);
            pdu.push_back(8'($urandom));
        end
        pdu.push_back(TAG_SEQUENCE);
        pdu.push_back(8'(binds.size()));
        foreach (binds[i]) pdu.push_back(binds[i]);

        for (k = 0; k < gen_comm_len; k++) begin
            if (k < COMMUNITY_MAX_BYTES) community.push_back(gen_comm_bytes[k*8 +: 8]);
            else community.push_back(8'($urandom));
        end
        if (!community_ok) begin
            if (community.size() > 0 && $urandom_range(0, 1) == 1) begin
                k = $urandom_range(0, community.size() - 1);
                community[k] = community[k] ^ 8'(1 << $urandom_range(0, 7));
            end else begin
                community.push_back(8'($urandom));
            end
        end

        payload.delete();
        payload.push_back(TAG_SEQUENCE);
        payload.push_back(8'(7 + community.size() + pdu.size()));
        payload.push_back(TAG_INTEGER);
        payload.push_back(8'd1);
        payload.push_back(8'd0);
        payload.push_back(TAG_OCTETS);
        payload.push_back(8'(community.size()));
        foreach (community[i]) payload.push_back(community[i]);
        payload.push_back(getnext ? TAG_GETNEXT : TAG_GET);
        payload.push_back(8'(pdu.size()));
        foreach (pdu[i]) payload.push_back(pdu[i]);
    endtask

    // break a share of the requests: stray byte, byte off by one, cut short,
    // trailing bytes, or plain noise
    task automatic mangle_payload();
        int pick;
        int k;
        pick = $urandom_range(0, 99);
        k    = $urandom_range(0, payload.size() - 1);
        if (pick < 10) begin
            payload[k] = 8'($urandom);
        end else if (pick < 20) begin
            payload[k] = payload[k] + (pick[0] ? 8'd1 : 8'hFF);
        end else if (pick < 25) begin
            while (payload.size() > k + 1) void'(payload.pop_back());
        end else if (pick < 30) begin
            repeat ($urandom_range(1, 3)) payload.push_back(8'($urandom));
        end else if (pick < 35) begin
            payload.delete();
            payload.push_back(pick[0] ? TAG_SEQUENCE : 8'($urandom));
            repeat ($urandom_range(0, 23)) payload.push_back(8'($urandom));
        end
    endtask

    initial begin
        int  phase_bytes;
        int  random_bytes;
        int  n_binds;
        int  cap;
        bit  pressure_done;
        phase_bytes   = 0;
        random_bytes  = 0;
        pressure_done = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests under the register values left by reset
        rx_idle_pct <= 30;
        compose_request(0, 0, 1'b0, 1'b1);
        send_payload();
        compose_request(1, 3, 1'b1, 1'b1);
        send_payload();
        payload = '{8'hFF};
        send_payload();
        payload = '{TAG_SEQUENCE};
        send_payload();

        for (int ph = 0; ph < SETTING_COUNT; ph++) begin
            settle_block();
            case (ph)
                0: load_settings(64'h0000_6369_6C62_7570, 4'd6, 8'd8, 8'd255);
                1: load_settings({64{1'b1}}, 4'd8, 8'd255, 8'd255);
                2: load_settings(64'd0, 4'd0, 8'd1, 8'd60);
                3: load_settings({$urandom, $urandom}, 4'($urandom_range(1, 7)), 8'd0, 8'd255);
                4: load_settings({$urandom, $urandom}, 4'd15, 8'd4, 8'd128);
                5: load_settings({$urandom, $urandom}, 4'($urandom_range(0, 8)),
                                 8'($urandom_range(1, 255)), 8'd0);
                default: load_settings({$urandom, $urandom}, 4'($urandom_range(0, 8)),
                                       8'($urandom_range(1, 12)), 8'($urandom_range(30, 255)));
            endcase
            phase_bytes = bytes_sent;
            while (bytes_sent - phase_bytes < RANDOM_BYTES / SETTING_COUNT) begin
                if (random_bytes < RANDOM_BYTES / 3) begin
                    tx_idle_pct = 9;
                    rx_idle_pct <= 58;
                end else if (random_bytes < 2 * RANDOM_BYTES / 3) begin
                    tx_idle_pct = 58;
                    rx_idle_pct <= 9;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    if (!pressure_done) begin
                        // stall the receiver while the sender keeps streaming
                        holds_asked <= holds_asked + 1;
                        pressure_done = 1;
                    end
                end
                cap     = (gen_bind_limit < 9) ? gen_bind_limit + 1 : 6;
                n_binds = $urandom_range(0, cap);
                compose_request(n_binds,
                                (n_binds <= 3 && $urandom_range(0, 9) == 0) ? 40 : 8,
                                1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0);
                mangle_payload();
                random_bytes += payload.size();
                send_payload();
            end
        end
        settle_block();
        repeat (4) @(posedge i_clk);

        $display("Covered %0d payload bytes in %0d requests across %0d register settings.",
                 bytes_sent, requests_sent, settings_used);
        $display("Checked %0d results: %0d accepted and %0d rejected requests.",
                 results_checked, accepts, rejects);
        if (mismatches == 0 && pending == 0)
            $display("snmp_v1_get_request_checker regression: pass");
        else
            $display("snmp_v1_get_request_checker regression: fail");
        $finish;
    end

endmodule
